// ===== rtl/serial_command_keyword_matcher_defines.svh =====
// ---------------------------------------------------------------------------
// Keyword matcher assertion macros
// Concurrent checks on clk, disabled while rst is high.
// ---------------------------------------------------------------------------
`ifndef SERIAL_COMMAND_KEYWORD_MATCHER_DEFINES_SVH
`define SERIAL_COMMAND_KEYWORD_MATCHER_DEFINES_SVH

`ifndef SYNTHESIS
// Check in the same cycle: when ante holds, cons must hold.
`define SCKM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("keyword matcher check failed");
// Check in the following cycle: when ante holds, cons must hold on the next edge.
`define SCKM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("keyword matcher check failed");
`else
`define SCKM_ASSERT_NOW(label, ante, cons)
`define SCKM_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== rtl/scmk_pkg.sv =====
// ---------------------------------------------------------------------------
// Keyword matcher package
// Sizes, character codes and the structs passed between the table and the
// line comparator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package scmk_pkg;

  localparam int MAX_SLOTS  = 4;
  localparam int NAME_LEN   = 16;
  localparam int LINE_LIMIT = 64;

  localparam int SIDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
  localparam int POS_W  = (NAME_LEN > 1) ? $clog2(NAME_LEN) : 1;
  localparam int FILL_W = $clog2(NAME_LEN + 1);
  localparam int LPOS_W = $clog2(LINE_LIMIT + 1);
  localparam int CMP_W  = (LPOS_W > FILL_W) ? LPOS_W : FILL_W;
  localparam int IDX_W  = 2;

  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [7:0] CHAR_CR = 8'h0D;

  localparam logic ACT_RECEIVE  = 1'b0;
  localparam logic ACT_REGISTER = 1'b1;

  // One byte landing in the table
  typedef struct packed {
    logic             valid;
    logic [SIDX_W-1:0] slot;
    logic [POS_W-1:0] pos;
    logic [7:0]       data;
  } name_wr_t;

  // Table occupancy seen by the comparator
  typedef struct packed {
    logic [MAX_SLOTS-1:0][FILL_W-1:0] fill;
    logic [CNT_W-1:0]                 count;
  } tbl_stat_t;

  // Line operation for this cycle
  typedef struct packed {
    logic       byte_en;
    logic       end_en;
    logic [7:0] data;
  } line_op_t;

endpackage

// ===== rtl/scmk_name_store.sv =====
// ---------------------------------------------------------------------------
// Keyword matcher name table
// Holds the registered names in per-slot byte lanes with a fill count each.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module scmk_name_store
  import scmk_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        reg_en,
  input  logic [7:0]                  reg_byte,
  input  logic                        reg_last,
  input  logic [POS_W-1:0]            rd_pos,
  output logic [MAX_SLOTS-1:0][7:0]   rd_byte,
  output tbl_stat_t                   stat,
  output name_wr_t                    wr
);

  logic [MAX_SLOTS-1:0][NAME_LEN-1:0][7:0] names;
  logic [MAX_SLOTS-1:0][FILL_W-1:0]        fill;
  logic [CNT_W-1:0]                        count;
  logic                                    name_zero;

  logic [SIDX_W-1:0] cur;
  logic [FILL_W-1:0] wpos;
  logic              room;
  logic              store;
  logic [7:0]        wbyte;

  always_comb begin
    cur   = SIDX_W'(count);
    wpos  = fill[cur];
    room  = count < CNT_W'(MAX_SLOTS);
    store = reg_en && room && (wpos < FILL_W'(NAME_LEN));
    // a zero byte ends the name: pad the rest with zero
    wbyte = name_zero ? 8'h00 : reg_byte;
  end

  always_comb begin
    wr.valid = store;
    wr.slot  = cur;
    wr.pos   = POS_W'(wpos);
    wr.data  = wbyte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      count     <= '0;
      name_zero <= 1'b0;
    end else if (reg_en && room) begin
      if (store) begin
        fill[cur] <= wpos + FILL_W'(1);
        name_zero <= (wbyte == 8'h00);
      end
      if (reg_last) begin
        count     <= count + CNT_W'(1);
        name_zero <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (store) begin
      names[cur][POS_W'(wpos)] <= wbyte;
    end
  end

  always_comb begin
    for (int s = 0; s < MAX_SLOTS; s++) begin
      rd_byte[s] = names[s][rd_pos];
    end
    stat.fill  = fill;
    stat.count = count;
  end

endmodule

// ===== rtl/scmk_line_cmp.sv =====
// ---------------------------------------------------------------------------
// Keyword matcher line comparator
// Keeps the line head, and per slot a mismatch and an ended flag over the
// prefix that both the line and the name have reached.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "serial_command_keyword_matcher_defines.svh"

module scmk_line_cmp
  import scmk_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  line_op_t                   op,
  input  name_wr_t                   wr,
  input  tbl_stat_t                  stat,
  input  logic [MAX_SLOTS-1:0][7:0]  rd_byte,
  output logic [POS_W-1:0]           rd_pos,
  output logic                       hit,
  output logic [IDX_W-1:0]           hit_idx
);

  logic [LPOS_W-1:0]             line_pos;
  logic [NAME_LEN-1:0][7:0]      line_buf;
  logic [NAME_LEN-1:0]           zmask;
  logic [MAX_SLOTS-1:0]          mismatch;
  logic [MAX_SLOTS-1:0]          ended;
  logic [MAX_SLOTS-1:0]          mismatch_next;
  logic [MAX_SLOTS-1:0]          ended_next;
  logic [MAX_SLOTS-1:0]          fin_ok;

  logic [CMP_W-1:0] lp_ext;
  logic             line_room;
  logic             head_room;

  assign rd_pos    = POS_W'(line_pos);
  assign lp_ext    = CMP_W'(line_pos);
  assign line_room = line_pos < LPOS_W'(LINE_LIMIT);
  assign head_room = lp_ext < CMP_W'(NAME_LEN);

  always_comb begin
    logic [CMP_W-1:0] fx;
    logic [7:0]       a;
    mismatch_next = mismatch;
    ended_next    = ended;
    fx            = '0;
    a             = 8'h00;
    if (op.end_en) begin
      mismatch_next = '0;
      ended_next    = '0;
    end else if (op.byte_en) begin
      if (line_room) begin
        for (int s = 0; s < MAX_SLOTS; s++) begin
          fx = CMP_W'(stat.fill[s]);
          if (!mismatch[s] && !ended[s] && (lp_ext < fx)) begin
            if (op.data != rd_byte[s]) begin
              mismatch_next[s] = 1'b1;
            end else if (op.data == 8'h00) begin
              ended_next[s] = 1'b1;
            end
          end
        end
      end
    end else if (wr.valid && (CMP_W'(wr.pos) < lp_ext)) begin
      // name catches up with a line byte already held
      a = line_buf[wr.pos];
      if (!mismatch[wr.slot] && !ended[wr.slot]) begin
        if (a != wr.data) begin
          mismatch_next[wr.slot] = 1'b1;
        end else if (a == 8'h00) begin
          ended_next[wr.slot] = 1'b1;
        end
      end
    end
  end

  always_comb begin
    logic [CMP_W-1:0] fx;
    fx = '0;
    for (int s = 0; s < MAX_SLOTS; s++) begin
      fx = CMP_W'(stat.fill[s]);
      if (lp_ext < fx) begin
        fin_ok[s] = !mismatch[s] && (ended[s] || (rd_byte[s] == 8'h00));
      end else begin
        fin_ok[s] = !mismatch[s] && (ended[s] || (fx == lp_ext) ||
                    (fx == CMP_W'(NAME_LEN)) || zmask[POS_W'(stat.fill[s])]);
      end
    end
  end

  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int s = MAX_SLOTS - 1; s >= 0; s--) begin
      if (fin_ok[s] && (CNT_W'(s) < stat.count)) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(s);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_pos <= '0;
      mismatch <= '0;
      ended    <= '0;
    end else begin
      mismatch <= mismatch_next;
      ended    <= ended_next;
      if (op.end_en) begin
        line_pos <= '0;
      end else if (op.byte_en && line_room) begin
        line_pos <= line_pos + LPOS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (op.byte_en && line_room && head_room) begin
      line_buf[POS_W'(line_pos)] <= op.data;
      zmask[POS_W'(line_pos)]    <= (op.data == 8'h00);
    end
  end

  `SCKM_ASSERT_NOW(a_flags_excl, 1'b1, (mismatch & ended) == '0)
  `SCKM_ASSERT_NOW(a_line_bound, 1'b1, line_pos <= LPOS_W'(LINE_LIMIT))
  `SCKM_ASSERT_NOW(a_hit_committed, hit, CNT_W'(hit_idx) < stat.count)

endmodule

// ===== rtl/serial_command_keyword_matcher.sv =====
// ---------------------------------------------------------------------------
// Serial command keyword matcher
// Input words (s_*): s_tuser selects the kind, 0 a received line byte and
// 1 a name byte for the next free command slot; s_tlast marks the last byte
// of a name. A CR or LF line byte closes the line and yields one output
// word (m_*): m_tuser says whether a registered name matched, m_tdata
// carries the first matching slot (zero on no match). Other words give no
// output. Up to four names of sixteen bytes; lines hold 64 bytes.
// Flow: a word is taken into the input register on acceptance and
// processed from there; a closing byte loads the result register,
// which drives m_tvalid. Throughput: one word per cycle while m_tready
// is high; words without a result flow on regardless.
// Reset: the name table is empty, the line is empty, no output pending.
// Stall: while an output word waits on m_tready, a closing byte in the
// input register holds and s_tready drops; earlier words are not lost.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "serial_command_keyword_matcher_defines.svh"

module serial_command_keyword_matcher
  import scmk_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] byte_value
  input  logic       s_tuser,   // [0] action
  input  logic       s_tlast,   // name_end
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [1:0] command_index, [7:2] zero
  output logic       m_tuser    // [0] matched
);

  // input register
  logic       in_vld;
  logic       in_action;
  logic [7:0] in_byte;
  logic       in_last;

  // result register
  logic             out_vld;
  logic             out_matched;
  logic [IDX_W-1:0] out_idx;

  logic is_eol;
  logic advance;

  logic                      reg_en;
  line_op_t                  op;
  name_wr_t                  wr;
  tbl_stat_t                 stat;
  logic [MAX_SLOTS-1:0][7:0] rd_byte;
  logic [POS_W-1:0]          rd_pos;
  logic                      hit;
  logic [IDX_W-1:0]          hit_idx;

  // A closing byte needs the result register free; anything else goes.
  assign is_eol   = (in_action == ACT_RECEIVE) &&
                    ((in_byte == CHAR_LF) || (in_byte == CHAR_CR));
  assign advance  = in_vld && (!is_eol || !out_vld || m_tready);
  assign s_tready = !in_vld || advance;

  assign reg_en     = advance && (in_action == ACT_REGISTER);
  assign op.byte_en = advance && (in_action == ACT_RECEIVE) && !is_eol;
  assign op.end_en  = advance && is_eol;
  assign op.data    = in_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_tready) begin
      in_vld <= s_tvalid;
    end
  end

  // payload: load on every accepted word
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_action <= s_tuser;
      in_byte   <= s_tdata;
      in_last   <= s_tlast;
    end
  end

  scmk_name_store u_store (
    .clk      (clk),
    .rst      (rst),
    .reg_en   (reg_en),
    .reg_byte (in_byte),
    .reg_last (in_last),
    .rd_pos   (rd_pos),
    .rd_byte  (rd_byte),
    .stat     (stat),
    .wr       (wr)
  );

  scmk_line_cmp u_cmp (
    .clk     (clk),
    .rst     (rst),
    .op      (op),
    .wr      (wr),
    .stat    (stat),
    .rd_byte (rd_byte),
    .rd_pos  (rd_pos),
    .hit     (hit),
    .hit_idx (hit_idx)
  );

  // Hold the result until taken; drop valid once taken with nothing new.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (op.end_en) begin
      out_vld <= 1'b1;
    end else if (m_tready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op.end_en) begin
      out_matched <= hit;
      out_idx     <= hit_idx;
    end
  end

  assign m_tvalid = out_vld;
  assign m_tuser  = out_matched;
  assign m_tdata  = {{(8 - IDX_W){1'b0}}, out_idx};

  `SCKM_ASSERT_NOW(a_busy_holds, !s_tready, in_vld)
  `SCKM_ASSERT_NEXT(a_result_shown, op.end_en, m_tvalid)
  `SCKM_ASSERT_NOW(a_miss_index, m_tvalid && !m_tuser, m_tdata == 8'h00)

endmodule
